// ----- design/bslp_pkg.sv -----
`timescale 1ns / 1ps

package bslp_pkg;

	// Fixed field widths of the poll, the configuration and the control-change packet.
	localparam int unsigned TIME_W     = 32;
	localparam int unsigned CC_W       = 7;
	localparam int unsigned DEBOUNCE_W = 8;
	localparam int unsigned INTERVAL_W = 16;
	localparam int unsigned CHAN_W     = 4;
	localparam int unsigned HEADER_W   = 4;
	localparam int unsigned STATUS_W   = 8;

	// Configuration port layout.
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_SHORT_EFFECT        = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SHORT_TOGGLE_EFFECT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_EFFECT         = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_TOGGLE_EFFECT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS         = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_INTERVAL_MS    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MIDI_CHANNEL        = 3'd6;

	// Register reset values.
	localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 8'd10;
	localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd500;
	localparam logic [CHAN_W-1:0]     CHANNEL_RESET  = 4'd1;

	// USB-MIDI control-change packet constants.
	localparam logic [HEADER_W-1:0] CC_CODE_INDEX = 4'hB;
	localparam logic [STATUS_W-1:0] CC_STATUS     = 8'hB0;
	localparam logic [CC_W-1:0]     CC_VALUE      = 7'd1;

	// Stream payload widths, padded to whole bytes.
	localparam int unsigned IN_DATA_W  = 40;
	localparam int unsigned OUT_DATA_W = 32;

	// Current configuration as seen by the press logic.
	typedef struct packed {
		logic [CC_W-1:0]       short_effect;
		logic [CC_W-1:0]       short_toggle_effect;
		logic [CC_W-1:0]       long_effect;
		logic [CC_W-1:0]       long_toggle_effect;
		logic [DEBOUNCE_W-1:0] debounce_ms;
		logic [INTERVAL_W-1:0] long_interval_ms;
		logic [CHAN_W-1:0]     midi_channel;
	} cfg_t;

	// Decision for one poll.
	typedef struct packed {
		logic            emit;
		logic [CC_W-1:0] control_number;
	} result_t;

endpackage

// ----- design/bslp_cfg_regs.sv -----
`timescale 1ns / 1ps

module bslp_cfg_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [bslp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bslp_pkg::CFG_DATA_W-1:0]    cfg_data,
	output bslp_pkg::cfg_t                     cfg
);
	import bslp_pkg::*;

	cfg_t cfg_q;

	// Register file; writes to an unused index are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.short_effect        <= '0;
			cfg_q.short_toggle_effect <= '0;
			cfg_q.long_effect         <= '0;
			cfg_q.long_toggle_effect  <= '0;
			cfg_q.debounce_ms         <= DEBOUNCE_RESET;
			cfg_q.long_interval_ms    <= INTERVAL_RESET;
			cfg_q.midi_channel        <= CHANNEL_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SHORT_EFFECT:        cfg_q.short_effect        <= cfg_data[CC_W-1:0];
				REG_SHORT_TOGGLE_EFFECT: cfg_q.short_toggle_effect <= cfg_data[CC_W-1:0];
				REG_LONG_EFFECT:         cfg_q.long_effect         <= cfg_data[CC_W-1:0];
				REG_LONG_TOGGLE_EFFECT:  cfg_q.long_toggle_effect  <= cfg_data[CC_W-1:0];
				REG_DEBOUNCE_MS:         cfg_q.debounce_ms         <= cfg_data[DEBOUNCE_W-1:0];
				REG_LONG_INTERVAL_MS:    cfg_q.long_interval_ms    <= cfg_data[INTERVAL_W-1:0];
				REG_MIDI_CHANNEL:        cfg_q.midi_channel        <= cfg_data[CHAN_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- design/bslp_press_fsm.sv -----
`timescale 1ns / 1ps

module bslp_press_fsm (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            advance,
	input  logic                            pin_level,
	input  logic [bslp_pkg::TIME_W-1:0]     now_ms,
	input  bslp_pkg::cfg_t                  cfg,
	output bslp_pkg::result_t               res
);
	import bslp_pkg::*;

	logic              is_pressed_q;
	logic              long_fired_q;
	logic              short_alt_q;
	logic              long_alt_q;
	logic [TIME_W-1:0] press_time_q;

	logic              is_pressed_n;
	logic              long_fired_n;
	logic              short_alt_n;
	logic              long_alt_n;
	logic [TIME_W-1:0] press_time_n;

	logic              low;
	logic              start;
	logic              fired_eff;
	logic [TIME_W-1:0] elapsed;
	logic              past_debounce;
	logic              past_interval;

	// A press that starts on this poll counts from this poll's timestamp.
	assign low           = ~pin_level;
	assign start         = low & ~is_pressed_q;
	assign press_time_n  = start ? now_ms : press_time_q;
	assign fired_eff     = start ? 1'b0 : long_fired_q;
	assign elapsed       = now_ms - press_time_n;
	assign past_debounce = elapsed > {{(TIME_W-DEBOUNCE_W){1'b0}}, cfg.debounce_ms};
	assign past_interval = elapsed > {{(TIME_W-INTERVAL_W){1'b0}}, cfg.long_interval_ms};

	// Press decision and effect selection for the poll in the input register.
	always_comb begin
		is_pressed_n       = is_pressed_q | low;
		long_fired_n       = fired_eff;
		short_alt_n        = short_alt_q;
		long_alt_n         = long_alt_q;
		res.emit           = 1'b0;
		res.control_number = cfg.short_effect;
		if (!low && is_pressed_q) begin
			is_pressed_n = 1'b0;
			if (past_debounce) begin
				if (long_fired_q) begin
					long_fired_n = 1'b0;
				end else begin
					res.emit = 1'b1;
					if (cfg.short_toggle_effect == '0) begin
						res.control_number = cfg.short_effect;
					end else if (short_alt_q) begin
						res.control_number = cfg.short_effect;
						short_alt_n        = 1'b0;
					end else begin
						res.control_number = cfg.short_toggle_effect;
						short_alt_n        = 1'b1;
					end
				end
			end
		end else if (low && past_interval && !fired_eff) begin
			long_fired_n = 1'b1;
			res.emit     = 1'b1;
			if (cfg.long_toggle_effect == '0) begin
				res.control_number = cfg.long_effect;
			end else if (long_alt_q) begin
				res.control_number = cfg.long_effect;
				long_alt_n         = 1'b0;
			end else begin
				res.control_number = cfg.long_toggle_effect;
				long_alt_n         = 1'b1;
			end
		end
	end

	// Press state moves on only when the poll leaves the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			is_pressed_q <= 1'b0;
			long_fired_q <= 1'b0;
			short_alt_q  <= 1'b0;
			long_alt_q   <= 1'b0;
			press_time_q <= '0;
		end else if (advance) begin
			is_pressed_q <= is_pressed_n;
			long_fired_q <= long_fired_n;
			short_alt_q  <= short_alt_n;
			long_alt_q   <= long_alt_n;
			press_time_q <= press_time_n;
		end
	end

endmodule

// ----- design/button_short_long_press_toggle.sv -----
`timescale 1ns / 1ps

// A poll is held in the input register; its packet goes to the result register (m_tvalid).
// Throughput: one poll per cycle while m_tready is high; the single result register
// and the one-entry input register set that figure.
// Reset: arst_n clears press state, empties both registers and loads the
// configuration defaults (debounce 10 ms, long interval 500 ms, channel 1).
module button_short_long_press_toggle (
	input  logic                                clk,
	input  logic                                arst_n,
	// Configuration write port.
	input  logic                                cfg_we,
	input  logic [bslp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [bslp_pkg::CFG_DATA_W-1:0]     cfg_data,
	// Button polls.
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [bslp_pkg::IN_DATA_W-1:0]      s_tdata,  // [0] pin_level, [32:1] now_ms, pad
	// Control-change packets.
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [bslp_pkg::OUT_DATA_W-1:0]     m_tdata   // [3:0] usb_header, [11:4] status_byte,
	                                                      // [18:12] control_number,
	                                                      // [25:19] control_value, pad
);
	import bslp_pkg::*;

	cfg_t    cfg;
	result_t res;

	logic              s1_valid_q;
	logic              pin_level_s1;
	logic [TIME_W-1:0] now_ms_s1;
	logic              advance;

	logic              out_valid_q;
	logic [CC_W-1:0]   control_number_q;
	logic [CHAN_W-1:0] channel_q;

	bslp_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// The poll in the input register is resolved once the result slot is free.
	assign advance  = s1_valid_q & (~out_valid_q | m_tready);
	assign s_tready = ~s1_valid_q | advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_tready) begin
			s1_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			pin_level_s1 <= s_tdata[0];
			now_ms_s1    <= s_tdata[TIME_W:1];
		end
	end

	bslp_press_fsm u_press_fsm (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.pin_level (pin_level_s1),
		.now_ms    (now_ms_s1),
		.cfg       (cfg),
		.res       (res)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res.emit;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.emit) begin
			control_number_q <= res.control_number;
			channel_q        <= cfg.midi_channel;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_DATA_W-HEADER_W-STATUS_W-2*CC_W){1'b0}},
	                   CC_VALUE,
	                   control_number_q,
	                   CC_STATUS | {{(STATUS_W-CHAN_W){1'b0}}, channel_q},
	                   CC_CODE_INDEX};

`ifndef SYNTHESIS
	// A held poll is never dropped from the input register.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !advance |=> s1_valid_q)
		else $error("poll lost from input register");

	// A waiting packet blocks resolution of the next poll.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !m_tready |-> !advance)
		else $error("result register overwritten while stalled");

	// Every emitted decision shows up as a packet.
	a_emit_shown: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res.emit |=> out_valid_q)
		else $error("emitted packet missing");
`endif

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
	import bslp_pkg::*;

	localparam int unsigned LIMIT_CYCLES = 400000;
	localparam int unsigned RANDOM_POLLS = 650;
	localparam int unsigned SETTLE_CYCLES = 6;
	// Index outside the register map; the block must drop writes to it.
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	// One control-change packet, first field in the highest bits.
	typedef struct packed {
		logic [CC_W-1:0]     control_value;
		logic [CC_W-1:0]     control_number;
		logic [STATUS_W-1:0] status_byte;
		logic [HEADER_W-1:0] usb_header;
	} cc_packet_t;

	localparam int unsigned PACKET_W = $bits(cc_packet_t);

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;

	// Register copies as the block should hold them.
	logic [CC_W-1:0]       cfg_short_cc = '0;
	logic [CC_W-1:0]       cfg_short_alt_cc = '0;
	logic [CC_W-1:0]       cfg_long_cc = '0;
	logic [CC_W-1:0]       cfg_long_alt_cc = '0;
	logic [DEBOUNCE_W-1:0] cfg_debounce = DEBOUNCE_RESET;
	logic [INTERVAL_W-1:0] cfg_interval = INTERVAL_RESET;
	logic [CHAN_W-1:0]     cfg_channel = CHANNEL_RESET;

	// Press tracking state.
	logic              held_down = 1'b0;
	logic              long_sent = 1'b0;
	logic              short_flip = 1'b0;
	logic              long_flip = 1'b0;
	logic [TIME_W-1:0] press_start_ms = '0;

	cc_packet_t        pending_packets[$];
	int unsigned       fail_count = 0;
	int unsigned       polls_sent = 0;
	int unsigned       cycle_count = 0;
	logic [TIME_W-1:0] clock_ms = '0;
	logic              gaps_on = 1'b1;
	logic              stalls_on = 1'b1;
	int unsigned       stall_left = 0;
	int unsigned       holdoff_left = 0;
	int unsigned       holdoff_request = 0;

	button_short_long_press_toggle i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),   // [0] pin_level, [32:1] now_ms, pad
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)    // [3:0] usb_header, [11:4] status_byte,
		                        // [18:12] control_number, [25:19] control_value, pad
	);

	always #10 clk = ~clk;

	// Run limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("button_short_long_press_toggle: mismatch");
			$finish;
		end
	end

	// Mostly no gap, often a short one, now and then a long one.
	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Alternates between the main and the alternate control when one is set.
	function automatic logic [CC_W-1:0] choose_control(input logic [CC_W-1:0] main_cc,
			input logic [CC_W-1:0] alt_cc, inout logic flip);
		if (alt_cc == '0)
			return main_cc;
		flip = !flip;
		return flip ? alt_cc : main_cc;
	endfunction

	function automatic void queue_packet(input logic [CC_W-1:0] control);
		cc_packet_t pkt;
		pkt.usb_header     = CC_CODE_INDEX;
		pkt.status_byte    = CC_STATUS | {4'h0, cfg_channel};
		pkt.control_number = control;
		pkt.control_value  = CC_VALUE;
		pending_packets.push_back(pkt);
	endfunction

	// Advances the press state for one accepted poll and queues its packet, if any.
	function automatic void predict_poll(input logic pin, input logic [TIME_W-1:0] now_ms);
		logic [TIME_W-1:0] held;
		if (!pin && !held_down) begin
			held_down = 1'b1;
			long_sent = 1'b0;
			press_start_ms = now_ms;
		end
		if (!held_down)
			return;
		held = now_ms - press_start_ms;
		if (pin) begin
			held_down = 1'b0;
			if (held <= cfg_debounce)
				return;
			if (long_sent) begin
				long_sent = 1'b0;
				return;
			end
			queue_packet(choose_control(cfg_short_cc, cfg_short_alt_cc, short_flip));
		end else if (held > cfg_interval && !long_sent) begin
			long_sent = 1'b1;
			queue_packet(choose_control(cfg_long_cc, cfg_long_alt_cc, long_flip));
		end
	endfunction

	// Packet receiver: random stalls plus a long hold-off on request.
	always @(negedge clk) begin
		if (holdoff_request != 0) begin
			holdoff_left = holdoff_request;
			holdoff_request = 0;
		end
		if (holdoff_left != 0) begin
			m_tready <= 1'b0;
			holdoff_left--;
		end else if (stall_left != 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else begin
			m_tready <= 1'b1;
			if (stalls_on)
				stall_left = pick_gap();
		end
	end

	// Compare each packet transaction with the oldest expected one.
	always @(posedge clk) begin
		cc_packet_t seen;
		cc_packet_t want;
		if (arst_n && m_tvalid && m_tready) begin
			seen = m_tdata[PACKET_W-1:0];
			if (pending_packets.size() == 0) begin
				$error("unexpected packet: control_number %0d", seen.control_number);
				fail_count++;
			end else begin
				want = pending_packets.pop_front();
				if (seen.usb_header !== want.usb_header) begin
					$error("usb_header: expected %0d, got %0d",
						want.usb_header, seen.usb_header);
					fail_count++;
				end
				if (seen.status_byte !== want.status_byte) begin
					$error("status_byte: expected %0d, got %0d",
						want.status_byte, seen.status_byte);
					fail_count++;
				end
				if (seen.control_number !== want.control_number) begin
					$error("control_number: expected %0d, got %0d",
						want.control_number, seen.control_number);
					fail_count++;
				end
				if (seen.control_value !== want.control_value) begin
					$error("control_value: expected %0d, got %0d",
						want.control_value, seen.control_value);
					fail_count++;
				end
			end
		end
	end

	// Offers one poll, keeping tvalid high across back-to-back transactions.
	task automatic send_poll(input logic pin, input logic [TIME_W-1:0] now_ms);
		int unsigned gap;
		gap = gaps_on ? pick_gap() : 0;
		@(negedge clk);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(IN_DATA_W - TIME_W - 1){1'b0}}, now_ms, pin};
		do @(posedge clk); while (!s_tready);
		predict_poll(pin, now_ms);
		polls_sent++;
	endtask

	// Drains all expected packets and lets the pipeline settle.
	task automatic wait_idle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_packets.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_SHORT_EFFECT:        cfg_short_cc = val[CC_W-1:0];
			REG_SHORT_TOGGLE_EFFECT: cfg_short_alt_cc = val[CC_W-1:0];
			REG_LONG_EFFECT:         cfg_long_cc = val[CC_W-1:0];
			REG_LONG_TOGGLE_EFFECT:  cfg_long_alt_cc = val[CC_W-1:0];
			REG_DEBOUNCE_MS:         cfg_debounce = val[DEBOUNCE_W-1:0];
			REG_LONG_INTERVAL_MS:    cfg_interval = val[INTERVAL_W-1:0];
			REG_MIDI_CHANNEL:        cfg_channel = val[CHAN_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Picks the next elapsed time of a press, often right at a threshold.
	function automatic int unsigned next_elapsed(input int unsigned held);
		int unsigned goal;
		case ($urandom_range(0, 4))
			0: begin
				goal = cfg_debounce + $urandom_range(0, 2);
				goal = (goal == 0) ? 0 : goal - 1;
			end
			1: begin
				goal = cfg_interval + $urandom_range(0, 2);
				goal = (goal == 0) ? 0 : goal - 1;
			end
			2: goal = held + $urandom_range(0, 3);
			default: goal = held + $urandom_range(0, cfg_interval + 30);
		endcase
		return (goal < held) ? held : goal;
	endfunction

	// A well-formed press: down, a few held polls, then up.
	task automatic random_press();
		logic [TIME_W-1:0] start_ms;
		int unsigned       held;
		int unsigned       hold_polls;
		start_ms = clock_ms;
		held = 0;
		hold_polls = $urandom_range(0, 4);
		send_poll(1'b0, start_ms);
		repeat (hold_polls) begin
			held = next_elapsed(held);
			send_poll(1'b0, start_ms + held);
		end
		held = next_elapsed(held);
		send_poll(1'b1, start_ms + held);
		clock_ms = start_ms + held + $urandom_range(1, 40);
	endtask

	// Reset configuration: idle, bounce at the limit, short and long press.
	task automatic test_default_settings();
		send_poll(1'b1, 32'd100);
		send_poll(1'b0, 32'd2000);
		send_poll(1'b1, 32'd2010);
		send_poll(1'b0, 32'd3000);
		send_poll(1'b1, 32'd3011);
		send_poll(1'b0, 32'd4000);
		send_poll(1'b0, 32'd4500);
		send_poll(1'b0, 32'd4501);
		send_poll(1'b1, 32'd4600);
		wait_idle();
	endtask

	// Alternating controls with both thresholds at zero.
	task automatic test_toggles_zero_intervals();
		write_reg(REG_SHORT_EFFECT, 16'd127);
		write_reg(REG_SHORT_TOGGLE_EFFECT, 16'd1);
		write_reg(REG_LONG_EFFECT, 16'd0);
		write_reg(REG_LONG_TOGGLE_EFFECT, 16'd127);
		write_reg(REG_DEBOUNCE_MS, 16'd0);
		write_reg(REG_LONG_INTERVAL_MS, 16'd0);
		write_reg(REG_MIDI_CHANNEL, 16'd15);
		// A zero-length press is still a bounce.
		send_poll(1'b0, 32'd50);
		send_poll(1'b1, 32'd50);
		// Two short presses pick the alternate, then the main control.
		send_poll(1'b0, 32'd60);
		send_poll(1'b1, 32'd61);
		send_poll(1'b0, 32'd70);
		send_poll(1'b1, 32'd71);
		// Long presses: silent on the first poll, fire one ms later, silent release.
		send_poll(1'b0, 32'd80);
		send_poll(1'b0, 32'd81);
		send_poll(1'b1, 32'd82);
		send_poll(1'b0, 32'd90);
		send_poll(1'b0, 32'd91);
		send_poll(1'b1, 32'd92);
		wait_idle();
	endtask

	// Wide write data, the unused index, maximum thresholds and timestamp wrap.
	task automatic test_wrap_and_masking();
		write_reg(REG_SHORT_EFFECT, 16'hFF85);
		write_reg(REG_UNUSED, 16'hFFFF);
		write_reg(REG_SHORT_TOGGLE_EFFECT, 16'hFF80);
		write_reg(REG_LONG_EFFECT, 16'h00AA);
		write_reg(REG_LONG_TOGGLE_EFFECT, 16'h0000);
		write_reg(REG_DEBOUNCE_MS, 16'hFFFF);
		write_reg(REG_LONG_INTERVAL_MS, 16'hFFFF);
		write_reg(REG_MIDI_CHANNEL, 16'hFFF0);
		// Long interval crossed across the wrap of the timestamp.
		send_poll(1'b0, 32'hFFFF_FFF0);
		send_poll(1'b0, 32'h0000_FFEF);
		send_poll(1'b0, 32'h0000_FFF0);
		send_poll(1'b1, 32'h0001_0000);
		// A timestamp that goes backward reads as a very long press.
		send_poll(1'b0, 32'd1000);
		send_poll(1'b1, 32'd999);
		// Release exactly at the maximum debounce, across the wrap.
		send_poll(1'b0, 32'hFFFF_FFFF);
		send_poll(1'b1, 32'd254);
		wait_idle();
	endtask

	// The receiver holds off while the sender keeps offering short presses.
	task automatic test_output_stall();
		write_reg(REG_DEBOUNCE_MS, 16'd0);
		write_reg(REG_LONG_INTERVAL_MS, 16'd3);
		write_reg(REG_SHORT_TOGGLE_EFFECT, 16'd33);
		gaps_on = 1'b0;
		stalls_on = 1'b0;
		@(posedge clk);
		holdoff_request = 150;
		repeat (20) begin
			send_poll(1'b0, clock_ms);
			send_poll(1'b1, clock_ms + 1);
			clock_ms = clock_ms + 5;
		end
		wait_idle();
	endtask

	// Phases of random presses, each under its own configuration.
	task automatic test_random_polls();
		logic [CFG_DATA_W-1:0] reg_vals [0:6];
		int unsigned           goal;
		int unsigned           phase;
		int unsigned           idx;
		int unsigned           roll;
		goal = polls_sent + RANDOM_POLLS;
		phase = 0;
		while (polls_sent < goal) begin
			gaps_on = (phase % 3) != 2;
			stalls_on = (phase % 4) != 3;
			case (phase)
				0: for (idx = 0; idx <= REG_MIDI_CHANNEL; idx++)
					reg_vals[idx] = '0;
				1: for (idx = 0; idx <= REG_MIDI_CHANNEL; idx++)
					reg_vals[idx] = '1;
				default: begin
					reg_vals[REG_SHORT_EFFECT] = CFG_DATA_W'($urandom());
					reg_vals[REG_LONG_EFFECT] = CFG_DATA_W'($urandom());
					reg_vals[REG_SHORT_TOGGLE_EFFECT] = CFG_DATA_W'($urandom_range(0, 2) == 0 ?
						($urandom() & 16'hFF80) : $urandom());
					reg_vals[REG_LONG_TOGGLE_EFFECT] = CFG_DATA_W'($urandom_range(0, 2) == 0 ?
						($urandom() & 16'hFF80) : $urandom());
					reg_vals[REG_DEBOUNCE_MS] = CFG_DATA_W'($urandom_range(0, 1) == 0 ?
						(($urandom() & 16'hFF00) | $urandom_range(0, 20)) : $urandom());
					case ($urandom_range(0, 3))
						0, 1: reg_vals[REG_LONG_INTERVAL_MS] =
							CFG_DATA_W'($urandom_range(0, 120));
						2: reg_vals[REG_LONG_INTERVAL_MS] = CFG_DATA_W'($urandom_range(0, 2000));
						default: reg_vals[REG_LONG_INTERVAL_MS] = CFG_DATA_W'($urandom());
					endcase
					reg_vals[REG_MIDI_CHANNEL] = CFG_DATA_W'($urandom());
				end
			endcase
			for (idx = 0; idx <= REG_MIDI_CHANNEL; idx++)
				write_reg(idx[CFG_IDX_W-1:0], reg_vals[idx]);
			if ($urandom_range(0, 3) == 0)
				write_reg(REG_UNUSED, CFG_DATA_W'($urandom()));
			// Some phases start just short of the timestamp wrap.
			clock_ms = (phase % 4 == 2) ? 32'hFFFF_FFFF - $urandom_range(0, 3000) : $urandom();
			repeat (15) begin
				roll = $urandom_range(0, 9);
				if (roll < 8)
					random_press();
				else if (roll == 8)
					send_poll(1'($urandom_range(0, 1)), $urandom());
				else
					send_poll(1'b1, clock_ms);
			end
			wait_idle();
			phase++;
		end
	endtask

	initial begin
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		test_default_settings();
		test_toggles_zero_intervals();
		test_wrap_and_masking();
		test_output_stall();
		test_random_polls();
		if (fail_count == 0)
			$display("button_short_long_press_toggle: match");
		else
			$display("button_short_long_press_toggle: mismatch");
		$finish;
	end

endmodule

// ----- filelist.f -----
design/bslp_pkg.sv
design/bslp_cfg_regs.sv
design/bslp_press_fsm.sv
design/button_short_long_press_toggle.sv
tb/testbench.sv
